/* sv/rbt_pkg.sv */
package rbt_pkg;

	// Table geometry and field widths
	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int ID_W       = 7;
	localparam int KIND_W     = 3;
	localparam int SIZE_W     = 16;
	localparam int REFS_W     = 16;
	localparam int STAT_W     = 3;

	localparam logic [ID_W-1:0]   MAX_ID      = ID_W'(MAX_BLOCKS);
	localparam logic [SIZE_W-1:0] LIMIT_RESET = SIZE_W'(1000);
	localparam logic [REFS_W-1:0] REFS_MAX    = '1;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EXPAND  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADD     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FREEALL = 3'd4;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NO_SPACE = 3'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_ID   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_REF_OVF  = 3'd4;

	// Decoded operation class, one bit per kind; all clear for unused kinds
	typedef struct packed {
		logic req;
		logic exp;
		logic add;
		logic rem;
		logic clr;
	} op_cls_t;

	// Classified item handed from the front to the back
	typedef struct packed {
		op_cls_t           cls;
		logic [ID_W-1:0]   block_id;
		logic [IDX_W-1:0]  idx;
		logic              id_ok;
		logic [SIZE_W-1:0] amount;
	} op_t;

	// Result item
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   result_id;
		logic [REFS_W-1:0] references;
		logic              freed;
		logic [SIZE_W-1:0] used_units;
		logic [ID_W-1:0]   issued_count;
	} res_t;

endpackage

/* sv/rbt_if.sv */
// Command channel
interface rbt_cmd_if import rbt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   block_id;
	logic [SIZE_W-1:0] amount;

	modport source (output valid, kind, block_id, amount, input ready);
	modport sink   (input valid, kind, block_id, amount, output ready);
endinterface

// Result channel
interface rbt_res_if import rbt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [ID_W-1:0]   result_id;
	logic [REFS_W-1:0] references;
	logic              freed;
	logic [SIZE_W-1:0] used_units;
	logic [ID_W-1:0]   issued_count;

	modport source (output valid, status, result_id, references, freed, used_units,
		issued_count, input ready);
	modport sink   (input valid, status, result_id, references, freed, used_units,
		issued_count, output ready);
endinterface

// Configuration write channel
interface rbt_cfg_if import rbt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] memory_limit;

	modport source (output valid, memory_limit, input ready);
	modport sink   (input valid, memory_limit, output ready);
endinterface

/* sv/rbt_front.sv */
module rbt_front import rbt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rbt_cmd_if.sink       cmd,
	output logic          push_valid,
	input  logic          push_ready,
	output op_t           push_op
);

	logic vld_s1;
	op_t  op_s1;
	op_t  op_d;

	// Take a new request whenever the stage is empty or drains this cycle
	assign cmd.ready  = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_op    = op_s1;

	// Decode the kind and range-check the target id
	always_comb begin
		op_d          = '0;
		op_d.block_id = cmd.block_id;
		op_d.idx      = IDX_W'(cmd.block_id - ID_W'(1));
		op_d.id_ok    = (cmd.block_id != '0) && (cmd.block_id <= MAX_ID);
		op_d.amount   = cmd.amount;
		case (cmd.kind)
			KIND_REQUEST: op_d.cls.req = 1'b1;
			KIND_EXPAND:  op_d.cls.exp = 1'b1;
			KIND_ADD:     op_d.cls.add = 1'b1;
			KIND_REMOVE:  op_d.cls.rem = 1'b1;
			KIND_FREEALL: op_d.cls.clr = 1'b1;
			default:      op_d.cls     = '0;
		endcase
	end

	// Hold the classified request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1 <= op_d;
		end
	end

endmodule

/* sv/rbt_fifo.sv */
module rbt_fifo import rbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  op_t  push_op,
	output logic pop_valid,
	input  logic pop_ready,
	output op_t  pop_op
);

	op_t        slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_op     = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

/* sv/rbt_back.sv */
module rbt_back import rbt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pop_valid,
	output logic     pop_ready,
	input  op_t      pop_op,
	rbt_cfg_if.sink  cfg,
	rbt_res_if.source res
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	// Block table
	logic [SIZE_W-1:0] size_mem [MAX_BLOCKS];
	logic [REFS_W-1:0] refs_mem [MAX_BLOCKS];

	logic              state_q;
	op_t               op_q;
	logic [SIZE_W-1:0] size_rd_q;
	logic [REFS_W-1:0] refs_rd_q;
	logic [SIZE_W-1:0] limit_q;
	logic [SIZE_W-1:0] units_q;
	logic [ID_W-1:0]   issued_q;
	logic              out_vld_q;
	res_t              res_q;

	logic              do_pop;
	logic              fire;
	logic [SIZE_W:0]   sum;
	logic              over;
	logic              live;
	logic [REFS_W-1:0] refs_dec;
	logic [SIZE_W-1:0] nxt_units;
	logic [ID_W-1:0]   nxt_issued;
	res_t              res_d;
	logic              size_we;
	logic              refs_we;
	logic [IDX_W-1:0]  wr_idx;
	logic [SIZE_W-1:0] size_wd;
	logic [REFS_W-1:0] refs_wd;

	assign pop_ready = (state_q == ST_IDLE);
	assign do_pop    = pop_valid && pop_ready;
	assign fire      = (state_q == ST_EXEC) && (!out_vld_q || res.ready);
	assign cfg.ready = 1'b1;

	assign sum      = {1'b0, units_q} + {1'b0, op_q.amount};
	assign over     = sum > {1'b0, limit_q};
	assign live     = op_q.id_ok && (op_q.block_id <= issued_q) && (refs_rd_q != '0);
	assign refs_dec = refs_rd_q - REFS_W'(1);

	// Carry out the operation on the entry that was read when the request was popped
	always_comb begin
		nxt_units        = units_q;
		nxt_issued       = issued_q;
		res_d            = '0;
		size_we          = 1'b0;
		refs_we          = 1'b0;
		wr_idx           = op_q.idx;
		size_wd          = size_rd_q + op_q.amount;
		refs_wd          = refs_rd_q + REFS_W'(1);
		if (op_q.cls.req) begin
			wr_idx = issued_q[IDX_W-1:0];
			if (over) begin
				res_d.status = STAT_NO_SPACE;
			end else if (issued_q >= MAX_ID) begin
				res_d.status = STAT_FULL;
			end else begin
				size_we              = 1'b1;
				refs_we              = 1'b1;
				size_wd              = op_q.amount;
				refs_wd              = REFS_W'(1);
				nxt_issued           = issued_q + ID_W'(1);
				nxt_units            = sum[SIZE_W-1:0];
				res_d.result_id      = issued_q + ID_W'(1);
				res_d.references     = REFS_W'(1);
			end
		end else if (op_q.cls.exp) begin
			res_d.result_id = op_q.block_id;
			if (!live) begin
				res_d.status = STAT_BAD_ID;
			end else begin
				res_d.references = refs_rd_q;
				if (over) begin
					res_d.status = STAT_NO_SPACE;
				end else begin
					size_we   = 1'b1;
					nxt_units = sum[SIZE_W-1:0];
				end
			end
		end else if (op_q.cls.add) begin
			res_d.result_id = op_q.block_id;
			if (!live) begin
				res_d.status = STAT_BAD_ID;
			end else if (refs_rd_q == REFS_MAX) begin
				res_d.status     = STAT_REF_OVF;
				res_d.references = refs_rd_q;
			end else begin
				refs_we          = 1'b1;
				res_d.references = refs_wd;
			end
		end else if (op_q.cls.rem) begin
			res_d.result_id = op_q.block_id;
			if (!live) begin
				res_d.status = STAT_BAD_ID;
			end else begin
				refs_we          = 1'b1;
				refs_wd          = refs_dec;
				res_d.references = refs_dec;
				if (refs_dec == '0) begin
					res_d.freed = 1'b1;
					nxt_units   = (size_rd_q <= units_q) ? units_q - size_rd_q : '0;
				end
			end
		end else if (op_q.cls.clr) begin
			nxt_units  = '0;
			nxt_issued = '0;
		end
		res_d.used_units   = nxt_units;
		res_d.issued_count = nxt_issued;
	end

	// Sequence read, then update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			limit_q   <= LIMIT_RESET;
			units_q   <= '0;
			issued_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.memory_limit;
			end
			case (state_q)
				ST_IDLE: begin
					if (do_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q  <= ST_IDLE;
						units_q  <= nxt_units;
						issued_q <= nxt_issued;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Latch the request and read its table entry
	always_ff @(posedge clk) begin
		if (do_pop) begin
			op_q      <= pop_op;
			size_rd_q <= size_mem[pop_op.idx];
			refs_rd_q <= refs_mem[pop_op.idx];
		end
		if (fire && size_we) begin
			size_mem[wr_idx] <= size_wd;
		end
		if (fire && refs_we) begin
			refs_mem[wr_idx] <= refs_wd;
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

	// Drive the result register
	assign res.valid        = out_vld_q;
	assign res.status       = res_q.status;
	assign res.result_id    = res_q.result_id;
	assign res.references   = res_q.references;
	assign res.freed        = res_q.freed;
	assign res.used_units   = res_q.used_units;
	assign res.issued_count = res_q.issued_count;

endmodule

/* sv/refcount_block_table.sv */
// Channel  Modport  Payload                                                          Handshake
// cmd      sink     kind, block_id, amount                                           valid/ready
// res      source   status, result_id, references, freed, used_units, issued_count   valid/ready
// cfg      sink     memory_limit                                                     valid/ready
//
// Each request passes through two back-end states: IDLE reads its table entry
// from the size and count memories, EXEC updates them and loads the result register.
// The back end takes no new request until EXEC is done; the front stage and a
// two-entry queue keep taking requests while the back end or the result stalls.
// Reset clears the counters and sets memory_limit to 1000; the table needs no clearing.
// A result waiting on res.ready holds the back end; the front stalls once the queue fills.
module refcount_block_table import rbt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rbt_cmd_if.sink    cmd,
	rbt_res_if.source  res,
	rbt_cfg_if.sink    cfg
);

	logic push_valid;
	logic push_ready;
	op_t  push_op;
	logic pop_valid;
	logic pop_ready;
	op_t  pop_op;

	rbt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	rbt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	rbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (pop_op),
		.cfg       (cfg),
		.res       (res)
	);

endmodule

/* sv/rbt_chk.sv */
module rbt_chk import rbt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [STAT_W-1:0] res_status,
	input logic [ID_W-1:0]   res_result_id,
	input logic [REFS_W-1:0] res_references,
	input logic              res_freed,
	input logic [SIZE_W-1:0] res_used_units,
	input logic [ID_W-1:0]   res_issued_count
);

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status)
			&& $stable(res_result_id) && $stable(res_references)
			&& $stable(res_used_units) && $stable(res_issued_count))
		else $error("result changed while stalled");

	// A release is a clean remove that left no references
	a_freed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_freed |-> res_status == STAT_OK && res_references == '0
			&& res_result_id != '0)
		else $error("release with bad status or count");

	// A full table refusal only when every id is issued
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STAT_FULL |-> res_issued_count == MAX_ID
			&& res_result_id == '0 && res_references == '0)
		else $error("table full reported with ids left");

	// Overflow only at the top count
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STAT_REF_OVF |-> res_references == REFS_MAX
			&& !res_freed)
		else $error("reference overflow below maximum");

endmodule

bind refcount_block_table rbt_chk u_rbt_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_status       (res.status),
	.res_result_id    (res.result_id),
	.res_references   (res.references),
	.res_freed        (res.freed),
	.res_used_units   (res.used_units),
	.res_issued_count (res.issued_count)
);

/* bench/tb_refcount_block_table.sv */
`timescale 1ns / 100ps

module tb_refcount_block_table;
	import rbt_pkg::*;

	localparam int CYCLE_LIMIT   = 1_500_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PCT      = 21;

	logic clk = 1'b0;
	logic arst_n;

	rbt_cmd_if cmd_ch();
	rbt_res_if res_ch();
	rbt_cfg_if cfg_ch();

	refcount_block_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Shadow of the block table and budget
	logic [SIZE_W-1:0] budget_units;
	logic [SIZE_W-1:0] units_held;
	logic [ID_W-1:0]   issued_ids;
	logic [SIZE_W-1:0] blk_size [MAX_BLOCKS];
	logic [REFS_W-1:0] blk_refs [MAX_BLOCKS];

	res_t outcome_q [$];

	bit no_stall = 1'b0;
	int items_sent = 0;
	int results_checked = 0;
	int limit_writes = 0;
	int error_count = 0;
	int cycle_count = 0;

	always #2 clk = ~clk;

	// Apply one request to the shadow table and return its outcome
	function automatic res_t table_apply(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
		logic [SIZE_W-1:0] amt);
		res_t r;
		int unsigned total;
		int unsigned idx;
		logic live;
		r = '0;
		total = units_held + amt;
		idx = (id == 0) ? 0 : id - 1;
		live = (id != 0 && id <= issued_ids) ? (blk_refs[idx] != 0) : 1'b0;
		case (k)
			KIND_REQUEST: begin
				// budget is tested before table space
				if (total > budget_units) begin
					r.status = STAT_NO_SPACE;
				end else if (issued_ids >= MAX_ID) begin
					r.status = STAT_FULL;
				end else begin
					blk_size[issued_ids] = amt;
					blk_refs[issued_ids] = REFS_W'(1);
					issued_ids++;
					units_held = SIZE_W'(total);
					r.result_id = issued_ids;
					r.references = REFS_W'(1);
				end
			end
			KIND_EXPAND: begin
				r.result_id = id;
				if (!live) begin
					r.status = STAT_BAD_ID;
				end else begin
					r.references = blk_refs[idx];
					if (total > budget_units) begin
						r.status = STAT_NO_SPACE;
					end else begin
						blk_size[idx] += amt;
						units_held = SIZE_W'(total);
					end
				end
			end
			KIND_ADD: begin
				r.result_id = id;
				if (!live) begin
					r.status = STAT_BAD_ID;
				end else if (blk_refs[idx] == REFS_MAX) begin
					r.status = STAT_REF_OVF;
					r.references = blk_refs[idx];
				end else begin
					blk_refs[idx]++;
					r.references = blk_refs[idx];
				end
			end
			KIND_REMOVE: begin
				r.result_id = id;
				if (!live) begin
					r.status = STAT_BAD_ID;
				end else begin
					blk_refs[idx]--;
					r.references = blk_refs[idx];
					// release the block's units when the last reference goes
					if (blk_refs[idx] == 0) begin
						units_held = (blk_size[idx] <= units_held) ?
							units_held - blk_size[idx] : '0;
						r.freed = 1'b1;
					end
				end
			end
			KIND_FREEALL: begin
				units_held = '0;
				issued_ids = '0;
			end
			default: ;
		endcase
		r.used_units = units_held;
		r.issued_count = issued_ids;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d expected %0d (result %0d)",
				name, got, want, results_checked));
		end
	endtask

	// Send one request, idling at random first; predict it once accepted
	task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
		input logic [SIZE_W-1:0] amt);
		while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.kind     <= k;
		cmd_ch.block_id <= id;
		cmd_ch.amount   <= amt;
		cmd_ch.valid    <= 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		outcome_q.push_back(table_apply(k, id, amt));
		items_sent++;
	endtask

	// Hold off requests until every outcome is back, then let the back end settle
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_memory_limit(input logic [SIZE_W-1:0] v);
		cfg_ch.memory_limit <= v;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		budget_units = v;
		limit_writes++;
	endtask

	// Drive ready at random and compare each result with the oldest outcome
	always @(posedge clk) begin : result_check
		res_t want;
		res_ch.ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (outcome_q.size() == 0) begin
				report_mismatch($sformatf("result with none expected: status %0d id %0d",
					res_ch.status, res_ch.result_id));
			end else begin
				want = outcome_q.pop_front();
				results_checked++;
				check_field("status", res_ch.status, want.status);
				check_field("result_id", res_ch.result_id, want.result_id);
				check_field("references", res_ch.references, want.references);
				check_field("freed", res_ch.freed, want.freed);
				check_field("used_units", res_ch.used_units, want.used_units);
				check_field("issued_count", res_ch.issued_count, want.issued_count);
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d outcomes outstanding",
				cycle_count, outcome_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Bad ids, budget edge at the reset limit, release, unused kinds
	task automatic test_directed();
		send_cmd(KIND_REMOVE, 7'd0, 16'd0);
		send_cmd(KIND_EXPAND, 7'd1, 16'd5);
		send_cmd(KIND_ADD, 7'd127, 16'hFFFF);
		send_cmd(KIND_REQUEST, 7'd0, 16'd0);
		send_cmd(KIND_REQUEST, 7'd0, 16'd1000);
		send_cmd(KIND_REQUEST, 7'd0, 16'd1);
		send_cmd(KIND_EXPAND, 7'd1, 16'd0);
		send_cmd(KIND_EXPAND, 7'd2, 16'd1);
		send_cmd(KIND_ADD, 7'd1, 16'd0);
		send_cmd(KIND_REMOVE, 7'd1, 16'd0);
		send_cmd(KIND_REMOVE, 7'd1, 16'd0);
		send_cmd(KIND_REMOVE, 7'd1, 16'd0);
		send_cmd(KIND_EXPAND, 7'd1, 16'd3);
		send_cmd(KIND_ADD, 7'd3, 16'd0);
		send_cmd(KIND_REMOVE, 7'd2, 16'hFFFF);
		send_cmd(KIND_REQUEST, 7'd0, 16'hFFFF);
		send_cmd(3'd5, 7'd2, 16'd7);
		send_cmd(3'd6, 7'd127, 16'hFFFF);
		send_cmd(3'd7, 7'd0, 16'h8000);
		send_cmd(KIND_REQUEST, 7'd127, 16'd40);
		send_cmd(KIND_FREEALL, 7'd3, 16'd9);
		send_cmd(KIND_ADD, 7'd1, 16'd0);
		send_cmd(KIND_REQUEST, 7'd0, 16'd10);
	endtask

	// Fill all ids, then check refusals and that released ids stay spent
	task automatic test_table_full();
		send_cmd(KIND_FREEALL, 7'd0, 16'd0);
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			send_cmd(KIND_REQUEST, 7'd0, 16'd1);
		end
		send_cmd(KIND_REQUEST, 7'd0, 16'd2000);
		send_cmd(KIND_REQUEST, 7'd0, 16'd0);
		send_cmd(KIND_ADD, MAX_ID, 16'd0);
		send_cmd(KIND_EXPAND, MAX_ID, 16'd5);
		send_cmd(KIND_ADD, MAX_ID + 7'd1, 16'd0);
		send_cmd(KIND_REMOVE, MAX_ID, 16'd0);
		send_cmd(KIND_REMOVE, MAX_ID, 16'd0);
		send_cmd(KIND_REQUEST, 7'd0, 16'd0);
		send_cmd(KIND_FREEALL, 7'd0, 16'd0);
		send_cmd(KIND_REQUEST, 7'd0, 16'd4);
	endtask

	// Count one block up with no stalls on either side, then step it down, up and down again
	task automatic test_ref_counts();
		send_cmd(KIND_FREEALL, 7'd0, 16'd0);
		send_cmd(KIND_REQUEST, 7'd0, 16'd12);
		no_stall = 1'b1;
		for (int i = 0; i < 60; i++) begin
			send_cmd(KIND_ADD, 7'd1, 16'($urandom_range(65535)));
		end
		no_stall = 1'b0;
		send_cmd(KIND_REMOVE, 7'd1, 16'd0);
		send_cmd(KIND_ADD, 7'd1, 16'd0);
		send_cmd(KIND_REMOVE, 7'd1, 16'd0);
		send_cmd(KIND_FREEALL, 7'd0, 16'd0);
	endtask

	// Budget at both ends of the register range
	task automatic test_limit_extremes();
		wait_idle();
		set_memory_limit('0);
		send_cmd(KIND_REQUEST, 7'd0, 16'd0);
		send_cmd(KIND_REQUEST, 7'd0, 16'd1);
		send_cmd(KIND_EXPAND, 7'd1, 16'd0);
		send_cmd(KIND_EXPAND, 7'd1, 16'd1);
		send_cmd(KIND_FREEALL, 7'd0, 16'd0);
		wait_idle();
		set_memory_limit('1);
		send_cmd(KIND_REQUEST, 7'd0, 16'hFFFF);
		send_cmd(KIND_EXPAND, 7'd1, 16'd1);
		send_cmd(KIND_REQUEST, 7'd0, 16'd0);
		send_cmd(KIND_REMOVE, 7'd1, 16'd0);
		send_cmd(KIND_REQUEST, 7'd0, 16'hFFFE);
		send_cmd(KIND_FREEALL, 7'd0, 16'd0);
	endtask

	// Mostly well-formed traffic on issued ids, across several budgets
	task automatic test_random();
		logic [SIZE_W-1:0] limits [5];
		logic [KIND_W-1:0] k;
		logic [ID_W-1:0] id;
		logic [SIZE_W-1:0] amt;
		int unsigned span;
		int unsigned pick;
		limits[0] = LIMIT_RESET;
		limits[1] = '1;
		limits[2] = '0;
		limits[3] = SIZE_W'($urandom_range(65535));
		limits[4] = SIZE_W'(40);
		for (int ph = 0; ph < 5; ph++) begin
			wait_idle();
			set_memory_limit(limits[ph]);
			span = (budget_units / 6 > 0) ? budget_units / 6 : 1;
			for (int n = 0; n < 115; n++) begin
				// pause once per phase until every outcome is back
				if (n == 57) begin
					wait_idle();
				end
				pick = $urandom_range(99);
				if (pick < 28) k = KIND_REQUEST;
				else if (pick < 42) k = KIND_EXPAND;
				else if (pick < 62) k = KIND_ADD;
				else if (pick < 96) k = KIND_REMOVE;
				else if (pick < 98) k = KIND_FREEALL;
				else k = KIND_W'($urandom_range(7, 5));
				if (issued_ids != 0 && $urandom_range(99) < 85) begin
					id = ID_W'($urandom_range(issued_ids, 1));
				end else begin
					id = ID_W'($urandom_range(127));
				end
				pick = $urandom_range(99);
				if (pick < 10) amt = SIZE_W'($urandom_range(65535));
				else if (pick < 20) amt = '0;
				else amt = SIZE_W'($urandom_range(span));
				send_cmd(k, id, amt);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.kind <= '0;
		cmd_ch.block_id <= '0;
		cmd_ch.amount <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.memory_limit <= '0;
		budget_units = LIMIT_RESET;
		units_held = '0;
		issued_ids = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		test_ref_counts();
		test_limit_extremes();
		test_random();
		wait_idle();

		$display("Sent %0d requests and checked %0d results over %0d budget settings",
			items_sent, results_checked, limit_writes);
		$display("Covered bad ids, full table, reference counting, budget extremes, random stalls");
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", error_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/rbt_pkg.sv
sv/rbt_if.sv
sv/rbt_front.sv
sv/rbt_fifo.sv
sv/rbt_back.sv
sv/refcount_block_table.sv
sv/rbt_chk.sv
bench/tb_refcount_block_table.sv
